[rtl/sha1_pkg.sv]
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1_pkg;

  localparam int unsigned HashWords  = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [31:0] SHA1_IV [HashWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_ROUND0 = 32'h5a827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
  localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] PAD_WORD = {PAD_BYTE, 24'h000000};

  // One word of a 512-bit block on its way from the front end to the core.
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;
  } q_entry_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = K_ROUND0;
    end else if (t < 7'd40) begin
      k = K_ROUND1;
    end else if (t < 7'd60) begin
      k = K_ROUND2;
    end else begin
      k = K_ROUND3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40 || t >= 7'd60) begin
      f = b ^ c ^ d;
    end else begin
      f = (b & c) | (b & d) | (c & d);
    end
    return f;
  endfunction

endpackage

[rtl/sha1_queue.sv]
// Small FIFO of block words between the padding front end and the core.
module sha1_queue import sha1_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t wr_data_i,
  input  logic     pop_i,
  output q_entry_t rd_data_o,
  output logic     full_o,
  output logic     empty_o
);

  q_entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;

  assign full_o    = (count_q == QueueCntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/sha1_front.sv]
// Input side: takes message items, counts the length and appends padding and length words.
module sha1_front import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output q_entry_t    q_entry_o
);

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_PADW   = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_LENLO  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  fill_q;
  logic [63:0] bit_len_q;
  logic [2:0]  cnt_sat;
  logic [4:0]  shamt;
  logic [31:0] keep_mask, pad_mask;

  assign cnt_sat   = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  assign shamt     = {cnt_sat[1:0], 3'b000};
  assign keep_mask = ~(32'hffffffff >> shamt);
  assign pad_mask  = PAD_WORD >> shamt;

  always_comb begin
    in_ready_o        = 1'b0;
    q_push_o          = 1'b0;
    q_entry_o.word    = '0;
    q_entry_o.msg_end = 1'b0;
    state_d           = state_q;
    case (state_q)
      ST_ACCEPT: begin
        in_ready_o = !q_full_i;
        q_push_o   = in_valid_i && !q_full_i;
        if (last_word_i && cnt_sat != 3'd4) begin
          q_entry_o.word = (data_word_i & keep_mask) | pad_mask;
        end else begin
          q_entry_o.word = data_word_i;
        end
        if (q_push_o && last_word_i) begin
          state_d = (cnt_sat == 3'd4) ? ST_PADW : ST_ZERO;
        end
      end
      ST_PADW: begin
        q_push_o       = !q_full_i;
        q_entry_o.word = PAD_WORD;
        if (q_push_o) begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        q_push_o = !q_full_i;
        // The high length word goes into slot 14; until then the block gets zeros.
        if (fill_q == 4'd14) begin
          q_entry_o.word = bit_len_q[63:32];
          if (q_push_o) begin
            state_d = ST_LENLO;
          end
        end
      end
      ST_LENLO: begin
        q_push_o          = !q_full_i;
        q_entry_o.word    = bit_len_q[31:0];
        q_entry_o.msg_end = 1'b1;
        if (q_push_o) begin
          state_d = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACCEPT;
      fill_q    <= '0;
      bit_len_q <= '0;
    end else begin
      state_q <= state_d;
      if (q_push_o) begin
        fill_q <= fill_q + 1'b1;
      end
      if (state_q == ST_ACCEPT && q_push_o) begin
        if (last_word_i) begin
          bit_len_q <= bit_len_q + {58'd0, cnt_sat, 3'b000};
        end else begin
          bit_len_q <= bit_len_q + 64'd32;
        end
      end else if (state_q == ST_LENLO && q_push_o) begin
        bit_len_q <= '0;
      end
    end
  end

endmodule

[rtl/sha1_core.sv]
// Compression core: gathers 16-word blocks, runs 80 rounds and emits the digest.
module sha1_core import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_entry_t    q_entry_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_result_o
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state_q;
  logic [3:0]  load_cnt_q;
  logic [6:0]  round_q;
  logic [2:0]  out_idx_q;
  logic        final_q;
  logic        out_valid_q;
  logic [31:0] chain_q [HashWords];
  logic [31:0] w_q [BlockWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] sched_new, round_sum;
  logic        out_load;

  assign q_pop_o     = (state_q == ST_LOAD) && !q_empty_i;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // The schedule window slides by one word per round: w_q[0] is always W[t].
  assign sched_new = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
  assign round_sum = rotl5(a_q) + round_f(round_q, b_q, c_q, d_q) + e_q
                     + round_k(round_q) + w_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      round_q     <= '0;
      out_idx_q   <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HashWords; i++) begin
        chain_q[i] <= SHA1_IV[i];
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (q_pop_o) begin
            load_cnt_q <= load_cnt_q + 1'b1;
            if (load_cnt_q == 4'(BlockWords - 1)) begin
              final_q <= q_entry_i.msg_end;
              round_q <= '0;
              state_q <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 1'b1;
          if (round_q == 7'(Rounds - 1)) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
          out_idx_q  <= '0;
          state_q    <= final_q ? ST_OUT : ST_LOAD;
        end
        ST_OUT: begin
          if (out_load) begin
            out_idx_q <= out_idx_q + 1'b1;
            // Once the last digest word sits in the output register the chain restarts.
            if (out_idx_q == 3'(HashWords - 1)) begin
              for (int i = 0; i < HashWords; i++) begin
                chain_q[i] <= SHA1_IV[i];
              end
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= q_entry_i.word;
      if (load_cnt_q == 4'(BlockWords - 1)) begin
        a_q <= chain_q[0];
        b_q <= chain_q[1];
        c_q <= chain_q[2];
        d_q <= chain_q[3];
        e_q <= chain_q[4];
      end
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= sched_new;
      a_q <= round_sum;
      b_q <= a_q;
      c_q <= rotl30(b_q);
      d_q <= c_q;
      e_q <= d_q;
    end
    if (out_load) begin
      digest_word_o <= chain_q[out_idx_q];
      word_index_o  <= out_idx_q;
      last_result_o <= (out_idx_q == 3'(HashWords - 1));
    end
  end

endmodule

[rtl/sha1_hash_engine_unit.sv]
// SHA-1 engine: one item per cycle into a 4-entry queue while it has room and no padding
// is being written; each 16-word block is then loaded, run through 80 rounds (one round
// per cycle) on the single shared round unit and added, while the queue takes new items.
// After a last item, padding adds up to 18 queue words; the digest leaves one word per
// cycle while out_ready_i is high, the first once the final block ends.
// Reset is asynchronous, active low: the chain returns to the initial values, queue empty.
module sha1_hash_engine_unit import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_result_o
);

  q_entry_t push_entry, pop_entry;
  logic     q_push, q_pop, q_full, q_empty;

  sha1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (push_entry)
  );

  sha1_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (push_entry),
    .pop_i     (q_pop),
    .rd_data_o (pop_entry),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  sha1_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_entry_i     (pop_entry),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_result_o (last_result_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_index_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_result_o |=> out_valid_o == 1'b0 ||
      word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest words out of order");

endmodule
